/* src/sphc_pkg.sv */
package sphc_pkg;

    localparam int WORD_W = 64;
    localparam int MSG_W  = 56;

    localparam logic [WORD_W-1:0] SIP_C0 = 64'h736f6d6570736575;
    localparam logic [WORD_W-1:0] SIP_C1 = 64'h646f72616e646f6d;
    localparam logic [WORD_W-1:0] SIP_C2 = 64'h6c7967656e657261;
    localparam logic [WORD_W-1:0] SIP_C3 = 64'h7465646279746573;

    localparam logic [WORD_W-MSG_W-1:0] SIP_LEN_BYTE   = 8'd7;
    localparam logic [WORD_W-1:0]       SIP_FINAL_MARK = 64'h00000000000000ff;

    // 2 compression rounds + 3 finalisation rounds, two half-round cells each
    localparam int C_ROUNDS    = 2;
    localparam int D_ROUNDS    = 3;
    localparam int N_CELLS     = 2 * (C_ROUNDS + D_ROUNDS);
    localparam int FINISH_CELL = 2 * C_ROUNDS - 1;

    localparam int IN_DATA_W  = 184;
    localparam int OUT_DATA_W = 256;

    typedef struct packed {
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
        logic [WORD_W-1:0] d;
    } t_sip_state;

    typedef struct packed {
        logic half;    // 0: first half of a SipRound, 1: second half
        logic finish;  // end of compression: fold block into a, mark into c
    } t_cell_ctl;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int s);
        rotl = (x << s) | (x >> (WORD_W - s));
    endfunction

endpackage

/* src/sphc_cell.sv */
module sphc_cell
    import sphc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  t_cell_ctl         i_ctl,
    input  logic              i_valid,
    input  t_sip_state        i_state,
    input  logic [WORD_W-1:0] i_blk,
    output logic              o_valid,
    output t_sip_state        o_state,
    output logic [WORD_W-1:0] o_blk
);

    logic              r_valid;
    t_sip_state        r_state;
    logic [WORD_W-1:0] r_blk;
    t_sip_state        n_state;

    logic [WORD_W-1:0] w_ha_a, w_ha_c;
    logic [WORD_W-1:0] w_hb_a, w_hb_c;
    t_sip_state        w_half;

    always_comb begin
        // first half: a+=b, c+=d, then rotate/xor
        w_ha_a = i_state.a + i_state.b;
        w_ha_c = i_state.c + i_state.d;
        // second half: c+=b, a+=d
        w_hb_c = i_state.c + i_state.b;
        w_hb_a = i_state.a + i_state.d;
        if (i_ctl.half) begin
            w_half.a = w_hb_a;
            w_half.b = rotl(i_state.b, 17) ^ w_hb_c;
            w_half.c = rotl(w_hb_c, 32);
            w_half.d = rotl(i_state.d, 21) ^ w_hb_a;
        end else begin
            w_half.a = rotl(w_ha_a, 32);
            w_half.b = rotl(i_state.b, 13) ^ w_ha_a;
            w_half.c = w_ha_c;
            w_half.d = rotl(i_state.d, 16) ^ w_ha_c;
        end
        n_state = w_half;
        if (i_ctl.finish) begin
            n_state.a = w_half.a ^ i_blk;
            n_state.c = w_half.c ^ SIP_FINAL_MARK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_state <= n_state;
            r_blk   <= i_blk;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;
    assign o_blk   = r_blk;

endmodule

/* src/siphash_single_block_core.sv */
// Channel   Dir  Handshake               Payload
// slave     in   i_s_tvalid/o_s_tready   i_s_tdata: key_low, key_high, message
// master    out  o_m_tvalid/i_m_tready   o_m_tdata: state_a .. state_d
//
// One beat per cycle while i_m_tready lets the row move; each half-round cell is a register stage.
// Ten cells in a row: two SipRounds of compression, three of finalisation.
// Stalls: the whole row holds while the last cell's beat waits on i_m_tready.
// The row moves whenever the last cell is empty or taken, so o_s_tready follows
// i_m_tready combinationally; empty slots further up are not squeezed out.
// Reset (i_rst_n low, synchronous) clears only the valid bits.
module siphash_single_block_core
    import sphc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // [63:0] key_low, [127:64] key_high, [183:128] message
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // [63:0] state_a, [127:64] state_b, [191:128] state_c, [255:192] state_d
    output logic [OUT_DATA_W-1:0] o_m_tdata
);

    logic [WORD_W-1:0] w_key_low, w_key_high;
    logic [MSG_W-1:0]  w_message;

    logic              w_valid [0:N_CELLS];
    t_sip_state        w_state [0:N_CELLS];
    logic [WORD_W-1:0] w_blk   [0:N_CELLS];
    t_cell_ctl         w_ctl   [0:N_CELLS-1];
    logic [N_CELLS-1:0] w_occ;
    logic              w_adv;

    assign w_key_low  = i_s_tdata[WORD_W-1:0];
    assign w_key_high = i_s_tdata[2*WORD_W-1:WORD_W];
    assign w_message  = i_s_tdata[2*WORD_W+MSG_W-1:2*WORD_W];

    // block = length byte on top of the seven message bytes
    assign w_blk[0]     = {SIP_LEN_BYTE, w_message};
    assign w_valid[0]   = i_s_tvalid;
    assign w_state[0].a = w_key_low  ^ SIP_C0;
    assign w_state[0].b = w_key_high ^ SIP_C1;
    assign w_state[0].c = w_key_low  ^ SIP_C2;
    assign w_state[0].d = w_key_high ^ SIP_C3 ^ w_blk[0];

    // row moves unless the last cell holds an untaken beat
    assign w_adv      = !w_valid[N_CELLS] || i_m_tready;
    assign o_s_tready = w_adv;

    genvar k;
    generate
        for (k = 0; k < N_CELLS; k++) begin : g_cell
            assign w_ctl[k].half   = (k % 2) == 1;
            assign w_ctl[k].finish = (k == FINISH_CELL);
            assign w_occ[k]        = w_valid[k+1];

            sphc_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_adv   (w_adv),
                .i_ctl   (w_ctl[k]),
                .i_valid (w_valid[k]),
                .i_state (w_state[k]),
                .i_blk   (w_blk[k]),
                .o_valid (w_valid[k+1]),
                .o_state (w_state[k+1]),
                .o_blk   (w_blk[k+1])
            );
        end
    endgenerate

    assign o_m_tvalid = w_valid[N_CELLS];
    assign o_m_tdata  = {w_state[N_CELLS].d, w_state[N_CELLS].c,
                         w_state[N_CELLS].b, w_state[N_CELLS].a};

    // a held row keeps its occupancy pattern
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(w_occ))
        else $error("cell occupancy changed during a stall");

    // first cell fills only from an accepted input beat
    a_first_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && !i_s_tvalid) |=> !w_valid[1])
        else $error("first cell filled without an input beat");

    // occupancy shifts by one cell on each move
    a_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> (w_occ[N_CELLS-1:1] == $past(w_occ[N_CELLS-2:0])))
        else $error("occupancy did not shift along the row");

endmodule

/* verif/siphash_single_block_core_tb.sv */
module siphash_single_block_core_tb;
    import sphc_pkg::*;

    typedef struct packed {
        logic [MSG_W-1:0]  msg;
        logic [WORD_W-1:0] k1;
        logic [WORD_W-1:0] k0;
    } t_key_beat;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_CHOKE, RX_PULSE} t_rx_mode;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata  = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;

    logic [OUT_DATA_W-1:0] digest_q [$];
    int unsigned           fault_cnt   = 0;
    int unsigned           burst_left  = 0;
    t_rx_mode              rx_mode     = RX_OPEN;
    int unsigned           rx_phase    = 0;
    int unsigned           pulse_cnt   = 0;

    string word_name [4] = '{"state_a", "state_b", "state_c", "state_d"};

    // corner keys and messages; no result here is obvious by eye, so all go
    // through the predictor
    t_key_beat corner_rows [13] = '{
        '{56'h0,                    64'h0,                    64'h0},
        '{56'hffffffffffffff,       64'hffffffffffffffff,     64'hffffffffffffffff},
        '{56'h0,                    64'h0,                    64'hffffffffffffffff},
        '{56'h0,                    64'hffffffffffffffff,     64'h0},
        '{56'hffffffffffffff,       64'h0,                    64'h0},
        '{56'h0,                    SIP_C1,                   SIP_C0},
        '{56'h0,                    SIP_C3,                   SIP_C2},
        '{56'h00000000000001,       64'h0,                    64'h0},
        '{56'h80000000000000,       64'h0,                    64'h0},
        '{56'h0,                    64'h0000000000000001,     64'h8000000000000000},
        '{56'haaaaaaaaaaaaaa,       64'haaaaaaaaaaaaaaaa,     64'h5555555555555555},
        '{56'h06050403020100,       64'h0f0e0d0c0b0a0908,     64'h0706050403020100},
        // fourth word cancels to zero once the block is absorbed
        '{56'h123456789abcde,       SIP_C3 ^ 64'h07123456789abcde, 64'h0}
    };

    siphash_single_block_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic [WORD_W-1:0] spin(input logic [WORD_W-1:0] x, input int s);
        logic [2*WORD_W-1:0] twin;
        twin = {x, x} >> (WORD_W - s);
        return twin[WORD_W-1:0];
    endfunction

    // SipHash state after 2 compression and 3 finalisation rounds,
    // packed state_a in the low word up to state_d in the top word
    function automatic logic [OUT_DATA_W-1:0] sip_digest(input t_key_beat kb);
        logic [WORD_W-1:0] v0, v1, v2, v3, blk;
        blk = {SIP_LEN_BYTE, kb.msg};
        v0  = kb.k0 ^ SIP_C0;
        v1  = kb.k1 ^ SIP_C1;
        v2  = kb.k0 ^ SIP_C2;
        v3  = kb.k1 ^ SIP_C3 ^ blk;
        for (int r = 0; r < C_ROUNDS + D_ROUNDS; r++) begin
            if (r == C_ROUNDS) begin
                v0 ^= blk;
                v2 ^= SIP_FINAL_MARK;
            end
            v0 += v1;
            v2 += v3;
            v1 = spin(v1, 13) ^ v0;
            v3 = spin(v3, 16) ^ v2;
            v0 = spin(v0, 32);
            v2 += v1;
            v0 += v3;
            v1 = spin(v1, 17) ^ v2;
            v3 = spin(v3, 21) ^ v0;
            v2 = spin(v2, 32);
        end
        return {v3, v2, v1, v0};
    endfunction

    // biased word: plain random half of the time, with zeros, ones,
    // lone set or cleared bits and sparse patterns mixed in
    function automatic logic [WORD_W-1:0] pick_word();
        logic [WORD_W-1:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       w = '0;
            1:       w = '1;
            2:       w = 64'd1 << $urandom_range(0, WORD_W - 1);
            3:       w = w & {$urandom, $urandom} & {$urandom, $urandom};
            4:       w = ~(64'd1 << $urandom_range(0, WORD_W - 1));
            default: ;
        endcase
        return w;
    endfunction

    // one beat in, with bursts and random gaps between them
    task automatic send_key(input t_key_beat kb);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 7);
            if (gap != 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? 64 : $urandom_range(1, 16);
        end
        i_s_tdata  <= kb;
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        burst_left--;
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        while (digest_q.size() != 0) @(posedge i_clk);
    endtask

    // receiver: switches between always ready, coin toss, heavy choke
    // and one-in-four pulses
    always @(posedge i_clk) begin
        if (rx_phase == 0) begin
            rx_mode  = t_rx_mode'($urandom_range(0, 3));
            rx_phase = $urandom_range(40, 300);
        end
        rx_phase--;
        pulse_cnt++;
        case (rx_mode)
            RX_OPEN:  i_m_tready <= 1'b1;
            RX_COIN:  i_m_tready <= ($urandom_range(0, 1) == 1);
            RX_CHOKE: i_m_tready <= ($urandom_range(0, 5) == 0);
            RX_PULSE: i_m_tready <= (pulse_cnt % 4 == 0);
            default:  i_m_tready <= 1'b1;
        endcase
    end

    // scoreboard: capture accepted input beats, check output beats
    always @(posedge i_clk) begin
        logic [OUT_DATA_W-1:0] want;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready)
                digest_q.push_back(sip_digest(t_key_beat'(i_s_tdata)));
            if (o_m_tvalid && i_m_tready) begin
                if (digest_q.size() == 0) begin
                    if (fault_cnt < 10)
                        $display("unexpected output beat %h", o_m_tdata);
                    fault_cnt++;
                end else begin
                    want = digest_q.pop_front();
                    for (int i = 0; i < 4; i++) begin
                        if (o_m_tdata[i*WORD_W +: WORD_W] !== want[i*WORD_W +: WORD_W]) begin
                            if (fault_cnt < 10)
                                $display("%s mismatch: expected %h got %h", word_name[i],
                                         want[i*WORD_W +: WORD_W],
                                         o_m_tdata[i*WORD_W +: WORD_W]);
                            fault_cnt++;
                        end
                    end
                end
            end
        end
    end

    initial begin
        t_key_beat         kb;
        logic [WORD_W-1:0] msg_word;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (corner_rows[i])
            send_key(corner_rows[i]);
        drain();

        for (int n = 0; n < 1300; n++) begin
            kb.k0    = pick_word();
            kb.k1    = pick_word();
            msg_word = pick_word();
            kb.msg   = msg_word[MSG_W-1:0];
            send_key(kb);
            if (n == 650)
                drain();
        end
        drain();

        repeat (30) @(posedge i_clk);
        if (fault_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

/* sim.f */
src/sphc_pkg.sv
src/sphc_cell.sv
src/siphash_single_block_core.sv
verif/siphash_single_block_core_tb.sv
